// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros. They are empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- src/dpb_pkg.sv -----
// ----------------------------------------------------------------------------
// dpb_pkg
// Types, widths and register indexes of the depth pixel back-projection block.
// ----------------------------------------------------------------------------
package dpb_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int PIX_W = 12;
  localparam int MAG_W = 16;
  localparam int INV_W = 24;
  localparam int A_W = MAG_W + INV_W;
  localparam int AHI_W = A_W - 32;
  localparam int PHI_W = AHI_W + 32;
  localparam int T_W = PHI_W + 1;
  localparam int R_W = T_W - 12;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_INV_FOCAL_X = 3'd2;
  localparam logic [2:0] REG_INV_FOCAL_Y = 3'd3;
  localparam logic [2:0] REG_INV_DEPTH_SCALE = 3'd4;
  localparam logic [2:0] REG_DEPTH_MIN = 3'd5;
  localparam logic [2:0] REG_DEPTH_MAX = 3'd6;
  localparam logic [2:0] REG_GRAY_MODE = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0] column;
    logic [PIX_W-1:0] row;
    logic [31:0]      depth_raw;
    logic             depth_valid;
    logic [7:0]       red_in;
    logic [7:0]       green_in;
    logic [7:0]       blue_in;
  } pix_in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [31:0]        point_z;
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;
  } point_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

endpackage

// ----- src/depth_pixel_backprojection.sv -----
// ----------------------------------------------------------------------------
// depth_pixel_backprojection
// Turns one depth pixel per clock into a colored 3D point of a pinhole camera.
// ----------------------------------------------------------------------------
// The block takes one pixel in every clock cycle; busy stays low. A pixel
// with a valid depth strictly between depth_min and depth_max gives one point
// on out_item, marked by out_valid; other pixels give nothing. In order, the
// pipeline stages are the depth multiply, the reciprocal multiply, the split
// depth multiply, the rounding add and the saturation.
// The receiver cannot stall the output. Configuration writes are always
// ready and should be made only while no pixel is in flight.
`include "assert_macros.svh"

module depth_pixel_backprojection #(
  parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dpb_pkg::pix_in_t    in_item,
  output logic                out_valid,
  output dpb_pkg::point_out_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int PIX_W = dpb_pkg::PIX_W;
  localparam int MAG_W = dpb_pkg::MAG_W;
  localparam int INV_W = dpb_pkg::INV_W;
  localparam int A_W = dpb_pkg::A_W;
  localparam int PHI_W = dpb_pkg::PHI_W;
  localparam int T_W = dpb_pkg::T_W;
  localparam logic [PIX_W-1:0] PIX_MASK =
    (COORD_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic [64:0] ROUND_44 = 65'd1 << 43;

  logic [15:0]       center_x_r, center_y_r;
  logic [INV_W-1:0]  inv_focal_x_r, inv_focal_y_r;
  logic [31:0]       inv_depth_scale_r, depth_min_r, depth_max_r;
  logic              gray_mode_r;

  logic              v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic              v1_nxt;
  logic              accept;

  logic [63:0]             prod1_r;
  logic [1:0][MAG_W-1:0]   mag1_r;
  logic [1:0]              neg1_r, neg2_r, neg3_r, neg4_r;
  dpb_pkg::color_t         col1_r, col2_r, col3_r, col4_r;
  logic [31:0]             z2_r, z3_r, z4_r;
  logic [1:0][A_W-1:0]     a2_r;
  logic [1:0][63:0]        plo3_r;
  logic [1:0][PHI_W-1:0]   phi3_r;
  logic [1:0][T_W-1:0]     t4_r;
  dpb_pkg::point_out_t     out_item_r;

  logic [1:0][PIX_W-1:0]   pix;
  logic [1:0][MAG_W-1:0]   pos, center;
  logic [1:0][MAG_W-1:0]   mag1_nxt;
  logic [1:0]              neg1_nxt;
  dpb_pkg::color_t         col1_nxt;
  logic [40:0]             zr;
  logic [31:0]             z2_nxt;
  logic [1:0][INV_W-1:0]   inv;
  logic [1:0][A_W-1:0]     a2_nxt;
  logic [1:0][63:0]        plo3_nxt;
  logic [1:0][PHI_W-1:0]   phi3_nxt;
  logic [1:0][64:0]        s4;
  logic [1:0][T_W-1:0]     t4_nxt;
  logic [1:0][31:0]        r5;
  logic [1:0][31:0]        coord_nxt;
  dpb_pkg::point_out_t     out_item_nxt;
  logic                    gray_copy_ok;
  logic                    origin_ok;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      inv_focal_x_r <= '0;
      inv_focal_y_r <= '0;
      inv_depth_scale_r <= 32'd16777216;
      depth_min_r <= 32'd6554;
      depth_max_r <= 32'd327680;
      gray_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dpb_pkg::REG_CENTER_X: center_x_r <= cfg_data[15:0];
        dpb_pkg::REG_CENTER_Y: center_y_r <= cfg_data[15:0];
        dpb_pkg::REG_INV_FOCAL_X: inv_focal_x_r <= cfg_data[INV_W-1:0];
        dpb_pkg::REG_INV_FOCAL_Y: inv_focal_y_r <= cfg_data[INV_W-1:0];
        dpb_pkg::REG_INV_DEPTH_SCALE: inv_depth_scale_r <= cfg_data;
        dpb_pkg::REG_DEPTH_MIN: depth_min_r <= cfg_data;
        dpb_pkg::REG_DEPTH_MAX: depth_max_r <= cfg_data;
        dpb_pkg::REG_GRAY_MODE: gray_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage 1: range check, depth product and signed offsets from the center.
  always_comb begin
    v1_nxt = accept && in_item.depth_valid &&
             (in_item.depth_raw > depth_min_r) && (in_item.depth_raw < depth_max_r);
    pix[0] = in_item.column & PIX_MASK;
    pix[1] = in_item.row & PIX_MASK;
    center[0] = center_x_r;
    center[1] = center_y_r;
    for (int l = 0; l < 2; l++) begin
      pos[l] = {pix[l], 4'b0000};
      neg1_nxt[l] = pos[l] < center[l];
      mag1_nxt[l] = neg1_nxt[l] ? (center[l] - pos[l]) : (pos[l] - center[l]);
    end
    col1_nxt.red = in_item.red_in;
    col1_nxt.green = gray_mode_r ? in_item.red_in : in_item.green_in;
    col1_nxt.blue = gray_mode_r ? in_item.red_in : in_item.blue_in;
  end

  // Stage 2: rounded and saturated depth, offset times reciprocal focal length.
  always_comb begin
    zr = {1'b0, prod1_r[63:24]} + 41'(prod1_r[23]);
    z2_nxt = (zr[40:32] != '0) ? 32'hFFFF_FFFF : zr[31:0];
    inv[0] = inv_focal_x_r;
    inv[1] = inv_focal_y_r;
    for (int l = 0; l < 2; l++) begin
      a2_nxt[l] = A_W'(mag1_r[l]) * A_W'(inv[l]);
    end
  end

  // Stage 3: the lateral product split into a low and a high partial product.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      plo3_nxt[l] = 64'(a2_r[l][31:0]) * 64'(z2_r);
      phi3_nxt[l] = PHI_W'(a2_r[l][A_W-1:32]) * PHI_W'(z2_r);
    end
  end

  // Stage 4: partial products joined with rounding at bit 43.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      s4[l] = {1'b0, plo3_r[l]} + ROUND_44;
      t4_nxt[l] = T_W'(s4[l][64:32]) + T_W'(phi3_r[l]);
    end
  end

  // Stage 5: sign and saturation.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      r5[l] = 32'(t4_r[l][T_W-1:12]);
      if (neg4_r[l]) begin
        coord_nxt[l] = 32'd0 - ((r5[l] > 32'h8000_0000) ? 32'h8000_0000 : r5[l]);
      end else begin
        coord_nxt[l] = (r5[l] > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : r5[l];
      end
    end
    out_item_nxt.point_x = coord_nxt[0];
    out_item_nxt.point_y = coord_nxt[1];
    out_item_nxt.point_z = z4_r;
    out_item_nxt.red_out = col4_r.red;
    out_item_nxt.green_out = col4_r.green;
    out_item_nxt.blue_out = col4_r.blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    prod1_r <= 64'(in_item.depth_raw) * 64'(inv_depth_scale_r);
    mag1_r <= mag1_nxt;
    neg1_r <= neg1_nxt;
    col1_r <= col1_nxt;
    z2_r <= z2_nxt;
    a2_r <= a2_nxt;
    neg2_r <= neg1_r;
    col2_r <= col1_r;
    plo3_r <= plo3_nxt;
    phi3_r <= phi3_nxt;
    z3_r <= z2_r;
    neg3_r <= neg2_r;
    col3_r <= col2_r;
    t4_r <= t4_nxt;
    z4_r <= z3_r;
    neg4_r <= neg3_r;
    col4_r <= col3_r;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item = out_item_r;

  assign gray_copy_ok = (out_item.green_out == out_item.red_out) &&
                        (out_item.blue_out == out_item.red_out);
  assign origin_ok = (out_item.point_x == 32'sd0) && (out_item.point_y == 32'sd0);

  `ASSERT_NEXT(a_drop_invalid, clk, rst_n, accept && !in_item.depth_valid, !v1_r)
  `ASSERT_SAME(a_latency, clk, rst_n, out_valid, $past(accept && in_item.depth_valid, 5))
  `ASSERT_SAME(a_gray_copy, clk, rst_n, out_valid && gray_mode_r, gray_copy_ok)
  `ASSERT_SAME(a_zero_depth, clk, rst_n, out_valid && (out_item.point_z == 32'd0), origin_ok)

endmodule
